// ===== rtl/utp_pkg.sv =====
// Package for the UUID text parser: status codes, character constants,
// character classification helpers and inter-module structs.
// No dependencies.
package utp_pkg;

  localparam logic [5:0] UUID_LEN = 6'd36;
  localparam logic [5:0] POS_MAX  = 6'd63;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [3:0] VERSION_NIBBLE = 4'h4;
  localparam logic [1:0] VARIANT_BITS   = 2'b10;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LENGTH  = 3'd1,
    ST_DASH    = 3'd2,
    ST_HEX     = 3'd3,
    ST_VERSION = 3'd4,
    ST_VARIANT = 3'd5
  } status_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nib_t;

  typedef struct packed {
    logic       dash_seen;
    logic [5:0] dash_pos;
    logic       digit_seen;
    logic [5:0] digit_pos;
  } fault_t;

  // Parser state as it stands after the current character.
  typedef struct packed {
    logic [5:0]  count;
    logic [63:0] upper;
    logic [63:0] lower;
    fault_t      faults;
  } snap_t;

  function automatic logic is_dash_slot(input logic [5:0] p);
    return (p == 6'd8) || (p == 6'd13) || (p == 6'd18) || (p == 6'd23);
  endfunction

  // Lowercase hex only; anything else reports not ok with a zero nibble.
  function automatic nib_t nibble_of(input logic [7:0] c);
    nib_t n;
    n.ok  = 1'b0;
    n.val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n.ok  = 1'b1;
      n.val = c[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n.ok  = 1'b1;
      n.val = c[3:0] + 4'd9;
    end
    return n;
  endfunction

endpackage

// ===== rtl/utp_in_if.sv =====
// Character request channel for the UUID text parser.
// No dependencies.
interface utp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== rtl/utp_out_if.sv =====
// Result request channel for the UUID text parser.
// No dependencies.
interface utp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] value_upper;
  logic [63:0] value_lower;
  logic [5:0]  error_position;

  modport source (output valid, output status, output value_upper, output value_lower,
                  output error_position, input ready);
  modport sink   (input valid, input status, input value_upper, input value_lower,
                  input error_position, output ready);
endinterface

// ===== rtl/uuid_text_parser_unit.sv =====
// Channel   Dir  Payload                                               Handshake
// in_chan   in   ch[7:0], last                                          valid/ready
// out_chan  out  status[2:0], value_upper/lower[63:0], error_position   valid/ready
//
// One character per cycle while the result register is not stalled. A character is held
// in the input register, then updates the parser state; the final character loads the
// result register, which presents the result as valid on out_chan.
// Synchronous active-low reset clears the parser state and both valid flags.
// A full result register that is not taken holds the input register, which in turn
// drops in_chan.ready; there are no bubbles while out_chan.ready stays high.
// Depends on utp_pkg, utp_in_if, utp_out_if, utp_char_stage, utp_result_stage.
module uuid_text_parser_unit (
  input  logic      clk,
  input  logic      rst_n,
  utp_in_if.sink    in_chan,
  utp_out_if.source out_chan
);
  import utp_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_ch_r;
  logic       in_last_r;
  logic       slot_free;
  logic       advance;
  logic       load;
  snap_t      snap;

  assign advance       = in_vld_r && slot_free;
  assign load          = advance && in_last_r;
  assign in_chan.ready = !in_vld_r || advance;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_chan.valid && in_chan.ready) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_ch_r   <= in_chan.ch;
      in_last_r <= in_chan.last;
    end
  end

  utp_char_stage u_char (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .ch    (in_ch_r),
    .last  (in_last_r),
    .snap  (snap)
  );

  utp_result_stage u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .snap      (snap),
    .slot_free (slot_free),
    .out_chan  (out_chan)
  );

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !slot_free |=> in_vld_r && $stable(in_ch_r) && $stable(in_last_r))
    else $error("held character changed while result stalled");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_chan.valid)
    else $error("result not presented after last character");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !out_chan.valid || out_chan.ready)
    else $error("result register overwritten before taken");

  a_epos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status == ST_OK || out_chan.status == ST_VERSION ||
                       out_chan.status == ST_VARIANT) |-> out_chan.error_position == 6'd0)
    else $error("error position set on a status without position");

endmodule

// ===== rtl/utp_char_stage.sv =====
// Per-character state update: position count, nibble shift register, fault capture.
// Depends on utp_pkg.
module utp_char_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    ch,
  input  logic          last,
  output utp_pkg::snap_t snap
);
  import utp_pkg::*;

  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] upper_r, upper_nxt;
  logic [63:0] lower_r, lower_nxt;
  fault_t      flt_r, flt_nxt;

  logic       in_range;
  logic       dash_slot;
  nib_t       nib;
  snap_t      upd;

  always_comb begin
    in_range  = pos_r < UUID_LEN;
    dash_slot = is_dash_slot(pos_r);
    nib       = nibble_of(ch);

    upd.count  = (pos_r < POS_MAX) ? pos_r + 6'd1 : POS_MAX;
    upd.upper  = upper_r;
    upd.lower  = lower_r;
    upd.faults = flt_r;

    if (in_range) begin
      if (dash_slot) begin
        if (ch != CH_DASH && !flt_r.dash_seen) begin
          upd.faults.dash_seen = 1'b1;
          upd.faults.dash_pos  = pos_r;
        end
      end else begin
        if (!nib.ok && !flt_r.digit_seen) begin
          upd.faults.digit_seen = 1'b1;
          upd.faults.digit_pos  = pos_r;
        end
        upd.upper = {upper_r[59:0], lower_r[63:60]};
        upd.lower = {lower_r[59:0], nib.val};
      end
    end
  end

  assign snap = upd;

  // The final character hands its snapshot on and clears the state for the next string.
  always_comb begin
    pos_nxt   = pos_r;
    upper_nxt = upper_r;
    lower_nxt = lower_r;
    flt_nxt   = flt_r;
    if (fire) begin
      if (last) begin
        pos_nxt   = '0;
        upper_nxt = '0;
        lower_nxt = '0;
        flt_nxt   = '0;
      end else begin
        pos_nxt   = upd.count;
        upper_nxt = upd.upper;
        lower_nxt = upd.lower;
        flt_nxt   = upd.faults;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      upper_r <= '0;
      lower_r <= '0;
      flt_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      upper_r <= upper_nxt;
      lower_r <= lower_nxt;
      flt_r   <= flt_nxt;
    end
  end

endmodule

// ===== rtl/utp_result_stage.sv =====
// Status priority decision and result output register.
// Depends on utp_pkg and utp_out_if.
module utp_result_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  utp_pkg::snap_t snap,
  output logic           slot_free,
  utp_out_if.source      out_chan
);
  import utp_pkg::*;

  logic        out_vld_r, out_vld_nxt;
  status_t     status_r, status_nxt;
  logic [63:0] upper_r;
  logic [63:0] lower_r;
  logic [5:0]  epos_r, epos_nxt;

  always_comb begin
    status_nxt = ST_OK;
    epos_nxt   = '0;
    if (snap.count != UUID_LEN) begin
      status_nxt = ST_LENGTH;
      epos_nxt   = snap.count;
    end else if (snap.faults.dash_seen) begin
      status_nxt = ST_DASH;
      epos_nxt   = snap.faults.dash_pos;
    end else if (snap.faults.digit_seen) begin
      status_nxt = ST_HEX;
      epos_nxt   = snap.faults.digit_pos;
    end else if (snap.upper[15:12] != VERSION_NIBBLE) begin
      status_nxt = ST_VERSION;
    end else if (snap.lower[63:62] != VARIANT_BITS) begin
      status_nxt = ST_VARIANT;
    end
  end

  assign slot_free = !out_vld_r || out_chan.ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      upper_r  <= snap.upper;
      lower_r  <= snap.lower;
      epos_r   <= epos_nxt;
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.status         = status_r;
  assign out_chan.value_upper    = upper_r;
  assign out_chan.value_lower    = lower_r;
  assign out_chan.error_position = epos_r;

endmodule
